### rtl/core/svps_pkg.sv
// shared types, register codes and reset constants for the servo pulse sequencer
package svps_pkg;

  localparam int unsigned NUM_CH = 2;

  localparam logic [15:0] RST_MIN_PULSE  = 16'd1300;
  localparam logic [15:0] RST_MAX_PULSE  = 16'd1700;
  localparam logic [15:0] RST_FRAME      = 16'd40000;
  localparam logic [15:0] RST_GUARD      = 16'd5;
  localparam logic [16:0] RST_WIDTH      = 17'd1500;

  typedef logic [16:0] ticks_t;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    REG_MIN_A  = 3'd0,
    REG_MAX_A  = 3'd1,
    REG_TRIM_A = 3'd2,
    REG_MIN_B  = 3'd3,
    REG_MAX_B  = 3'd4,
    REG_TRIM_B = 3'd5,
    REG_FRAME  = 3'd6,
    REG_GUARD  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [15:0] min_a;
    logic        [15:0] max_a;
    logic signed [15:0] trim_a;
    logic        [15:0] min_b;
    logic        [15:0] max_b;
    logic signed [15:0] trim_b;
    logic        [15:0] frame;
    logic        [15:0] guard;
  } cfg_t;

endpackage

### rtl/core/svps_cfg.sv
// configuration register file
module svps_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               we,
  input  logic [2:0]         index,
  input  logic [15:0]        data,
  output svps_pkg::cfg_t     cfg
);

  svps_pkg::cfg_t cfg_r;
  svps_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (we) begin
      case (index)
        svps_pkg::REG_MIN_A:  cfg_nxt.min_a  = data;
        svps_pkg::REG_MAX_A:  cfg_nxt.max_a  = data;
        svps_pkg::REG_TRIM_A: cfg_nxt.trim_a = $signed(data);
        svps_pkg::REG_MIN_B:  cfg_nxt.min_b  = data;
        svps_pkg::REG_MAX_B:  cfg_nxt.max_b  = data;
        svps_pkg::REG_TRIM_B: cfg_nxt.trim_b = $signed(data);
        svps_pkg::REG_FRAME:  cfg_nxt.frame  = data;
        svps_pkg::REG_GUARD:  cfg_nxt.guard  = data;
        default:              cfg_nxt        = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_a  <= svps_pkg::RST_MIN_PULSE;
      cfg_r.max_a  <= svps_pkg::RST_MAX_PULSE;
      cfg_r.trim_a <= '0;
      cfg_r.min_b  <= svps_pkg::RST_MIN_PULSE;
      cfg_r.max_b  <= svps_pkg::RST_MAX_PULSE;
      cfg_r.trim_b <= '0;
      cfg_r.frame  <= svps_pkg::RST_FRAME;
      cfg_r.guard  <= svps_pkg::RST_GUARD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/svps_width.sv
// per-channel pulse width store with trim and clamp
module svps_width (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       set_en,
  input  logic [7:0]                 channel,
  input  logic [15:0]                pulse_us,
  input  svps_pkg::cfg_t             cfg,
  output logic [1:0][16:0]           ticks,
  output logic [15:0]                rd_width
);

  logic [1:0][16:0]   ticks_r;
  logic [1:0][16:0]   ticks_nxt;
  logic               ch_ok;
  logic               idx;
  logic signed [17:0] lo;
  logic signed [17:0] hi;
  logic signed [17:0] trim;
  logic signed [17:0] sum;
  logic signed [17:0] clamped;
  svps_pkg::ticks_t   new_ticks;

  assign ch_ok = channel < 8'(svps_pkg::NUM_CH);
  assign idx   = channel[0];

  always_comb begin
    lo   = $signed({2'b00, idx ? cfg.min_b : cfg.min_a});
    hi   = $signed({2'b00, idx ? cfg.max_b : cfg.max_a});
    trim = idx ? {{2{cfg.trim_b[15]}}, cfg.trim_b} : {{2{cfg.trim_a[15]}}, cfg.trim_a};
    sum  = $signed({2'b00, pulse_us}) + trim;
    // when the limits cross, a sum below the minimum gives the minimum, any other the maximum
    if (sum < lo) begin
      clamped = lo;
    end else if (sum > hi) begin
      clamped = hi;
    end else begin
      clamped = sum;
    end
    new_ticks = {clamped[15:0], 1'b0};
  end

  always_comb begin
    ticks_nxt = ticks_r;
    if (set_en && ch_ok) begin
      ticks_nxt[idx] = new_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= {svps_pkg::RST_WIDTH, svps_pkg::RST_WIDTH};
    end else begin
      ticks_r <= ticks_nxt;
    end
  end

  assign ticks    = ticks_r;
  assign rd_width = ch_ok ? ticks_nxt[idx][15:0] : 16'd0;

endmodule

### rtl/core/svps_seq.sv
// tick counter, compare match and channel sequencing
module svps_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_en,
  input  logic [15:0]       frame,
  input  logic [15:0]       guard,
  input  logic [1:0][16:0]  ticks,
  output logic [1:0]        levels_nxt
);

  logic [15:0] tick_r;
  logic [15:0] tick_nxt;
  logic [15:0] cmp_r;
  logic [15:0] cmp_nxt;
  logic [1:0]  chan_r;
  logic [1:0]  chan_nxt;
  logic [1:0]  lvl_r;
  logic [1:0]  lvl_nxt;
  logic [15:0] tick_inc;
  logic [15:0] base;
  logic [16:0] guard_sum;

  assign tick_inc = tick_r + 16'd1;

  always_comb begin
    tick_nxt  = tick_en ? tick_inc : tick_r;
    cmp_nxt   = cmp_r;
    chan_nxt  = chan_r;
    lvl_nxt   = lvl_r;
    base      = tick_inc;
    guard_sum = '0;
    if (tick_en && (tick_inc == cmp_r)) begin
      if (!chan_r[1]) begin
        lvl_nxt[chan_r[0]] = 1'b0;
        chan_nxt           = chan_r + 2'd1;
      end else begin
        // end of frame: restart the count with the first channel
        tick_nxt = '0;
        chan_nxt = '0;
        base     = '0;
      end
      if (!chan_nxt[1]) begin
        cmp_nxt              = base + ticks[chan_nxt[0]][15:0];
        lvl_nxt[chan_nxt[0]] = 1'b1;
      end else begin
        guard_sum = {1'b0, base} + {1'b0, guard};
        cmp_nxt   = (guard_sum < {1'b0, frame}) ? frame : guard_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      cmp_r  <= '0;
      chan_r <= '0;
      lvl_r  <= '0;
    end else begin
      tick_r <= tick_nxt;
      cmp_r  <= cmp_nxt;
      chan_r <= chan_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

  assign levels_nxt = lvl_nxt;

endmodule

### rtl/core/servo_pulse_sequencer.sv
// top level of the two-channel sequential servo pulse sequencer
// Usage:
//   in_*  channel carries one item per transfer: a tick (mode 0), a width
//   set (mode 1) or a width read (mode 2 or 3), with channel and pulse_us.
//   out_* channel returns one result per item, in order: pin levels after
//   the item and the stored width of the addressed channel (0 if channel
//   is 2 or more).
//   cfg_* channel writes the eight 16-bit registers; it is always ready.
//   It must be written only while no item is in flight; not enforced.
// Pipeline: an item is held in the input register, then its state
//   update and result are computed in one pass into the output register.
//   The result is valid once the item reaches the output register; one item
//   per cycle is sustained while out_ready is high.
// Stall: while out_ready is low the result holds and the input register
//   keeps one more item; in_ready drops only when both are full.
// Reset (synchronous, active low): counter, compare value and active
//   channel clear, both widths return to 1500 ticks, out_valid goes low and the
//   registers take their default values.
module servo_pulse_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_channel,
  input  logic [15:0] in_pulse_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_pin_levels,
  output logic [15:0] out_width_ticks,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic              in_valid_r;
  logic [1:0]        mode_r;
  logic [7:0]        channel_r;
  logic [15:0]       pulse_us_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [1:0]        pin_levels_r;
  logic [15:0]       width_ticks_r;
  logic              advance;
  logic              in_take;
  logic              tick_en;
  logic              set_en;
  logic [1:0]        levels_nxt;
  logic [15:0]       rd_width;
  logic [1:0][16:0]  ticks;
  svps_pkg::cfg_t    cfg;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign in_take   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign tick_en   = advance && (mode_r == svps_pkg::MODE_TICK);
  assign set_en    = advance && (mode_r == svps_pkg::MODE_SET);

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_take || (in_valid_r && !advance);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      mode_r     <= in_mode;
      channel_r  <= in_channel;
      pulse_us_r <= in_pulse_us;
    end
    if (advance) begin
      pin_levels_r  <= levels_nxt;
      width_ticks_r <= rd_width;
    end
  end

  svps_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_valid),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  svps_width u_width (
    .clk      (clk),
    .rst_n    (rst_n),
    .set_en   (set_en),
    .channel  (channel_r),
    .pulse_us (pulse_us_r),
    .cfg      (cfg),
    .ticks    (ticks),
    .rd_width (rd_width)
  );

  svps_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_en    (tick_en),
    .frame      (cfg.frame),
    .guard      (cfg.guard),
    .ticks      (ticks),
    .levels_nxt (levels_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_pin_levels  = pin_levels_r;
  assign out_width_ticks = width_ticks_r;

endmodule

### rtl/core/svps_checker.sv
// port-level checks for the servo pulse sequencer, bound to the top level
module svps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_pin_levels,
  input logic [15:0] out_width_ticks
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pin_levels)
      && $stable(out_width_ticks))
    else $error("result changed while stalled");

  // pulses go one after the other, never two high together
  a_one_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pin_levels != 2'b11)
    else $error("both servo outputs high");

  // a draining receiver never blocks the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while receiver ready");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind servo_pulse_sequencer svps_checker u_svps_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pin_levels  (out_pin_levels),
  .out_width_ticks (out_width_ticks)
);
